[rtl/obp_pkg.sv]
// Shared types, constants and codes for the online bin packing block.
`default_nettype none

package obp_pkg;

  // Sizing
  localparam int MAX_BINS    = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int BIN_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);

  // Field widths of the channels
  localparam int WEIGHT_W  = 16;
  localparam int ROOM_W    = 16;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
    WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE     = 1'b1;

  localparam logic [ROOM_W-1:0] CAPACITY_RST = 16'd100;

  // Fit modes; the unused code behaves as best fit
  localparam logic [1:0] FIT_NEXT  = 2'd0;
  localparam logic [1:0] FIT_FIRST = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_TOO_HEAVY = 2'd1,
    ST_NO_BINS   = 2'd2
  } status_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                start_req;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] bin_index;
    status_t              status;
    logic [OUT_CNT_W-1:0] bins_used;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic rd_issue;
    logic place;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic too_heavy;
    logic none_open;
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/online_bin_packing.sv]
// Top level of the online bin packing block: sequencer plus datapath.
// Sequence: accept, evaluate, scan the bins (every open bin for first and best
//   fit, the last opened bin only for next fit), place, deliver; the scan is
//   skipped with no open bin, and an item over capacity goes straight to deliver.
// A new item is taken only once the last result is loaded into the output
//   register; the single read port of the room store is read once per bin in the scan.
// Reset: synchronous, active low; clears the sequencer, bin count and
//   output valid, restores capacity 100 and next fit. Room store not cleared.
`default_nettype none

module online_bin_packing (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire obp_pkg::in_item_t              in_data,
  // Result channel
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      obp_pkg::out_item_t             out_data,
  // Configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [obp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [obp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import obp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer: takes a transfer only when idle, holds the result in DONE
  // until the output register is free.
  obp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: room store, pipelined scan compare (each read is compared in the cycle
  // after it is issued), write-back and output register.
  obp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // An accepted transfer blocks the next one until its result is loaded for output
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again directly after a transfer");

  // Sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.eval, cmd.rd_issue, cmd.place, cmd.out_load}))
    else $error("more than one sequencer command at once");

  // Error results always name bin zero
  a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_PLACED)) |-> (out_data.bin_index == '0))
    else $error("error result with non-zero bin index");

  // A new result is only loaded when the output register was free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a stalled transfer");

endmodule

`default_nettype wire

[rtl/obp_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module obp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/obp_ctrl.sv]
// Sequencer for the bin packing block: accept, evaluate, scan, place, deliver.
`default_nettype none

module obp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire obp_pkg::dp_sts_t  sts,
  output      obp_pkg::ctl_cmd_t cmd
);
  import obp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.too_heavy) begin
          state_nxt = S_DONE;
        end else if (sts.none_open) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

[rtl/obp_dp.sv]
// Datapath of the bin packing block: registers, room store, scan compare, result.
`default_nettype none

module obp_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire obp_pkg::in_item_t                  in_data,
  input  wire logic                               out_stall,
  output      logic                               out_valid,
  output      obp_pkg::out_item_t                 out_data,
  input  wire logic                               cfg_we,
  input  wire logic [obp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [obp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire obp_pkg::ctl_cmd_t                  cmd,
  output      obp_pkg::dp_sts_t                   sts
);
  import obp_pkg::*;

  logic [ROOM_W-1:0]   cap_r;
  logic [1:0]          mode_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [CNT_W-1:0]    open_bins_r;
  logic [BIN_W-1:0]    cur_bin_r;
  logic [BIN_W-1:0]    scan_idx_r;
  logic [BIN_W-1:0]    scan_end_r;
  logic                cmp_v_r;
  logic [BIN_W-1:0]    cmp_idx_r;
  logic                found_r;
  logic [BIN_W-1:0]    pick_r;
  logic [ROOM_W-1:0]   best_r;
  out_item_t           res_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [ROOM_W-1:0]   rd_room;
  logic                best_mode;
  logic                take;
  logic                full;
  logic                ram_we;
  logic [BIN_W-1:0]    ram_waddr;
  logic [ROOM_W-1:0]   ram_wdata;
  logic [BIN_W-1:0]    new_bin;
  logic [CNT_W-1:0]    open_inc;

  obp_ram #(
    .WIDTH (ROOM_W),
    .DEPTH (MAX_BINS)
  ) u_room (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (scan_idx_r),
    .rdata (rd_room)
  );

  assign best_mode = (mode_r != FIT_NEXT) && (mode_r != FIT_FIRST);
  assign take      = cmp_v_r && (rd_room >= ROOM_W'(w_r)) &&
                     (!found_r || (best_mode && (rd_room < best_r)));
  assign full      = (open_bins_r >= CNT_W'(MAX_BINS));
  assign new_bin   = open_bins_r[BIN_W-1:0];
  assign open_inc  = CNT_W'(open_bins_r + 1'b1);

  assign ram_we    = cmd.place && (found_r || !full);
  assign ram_waddr = found_r ? pick_r : new_bin;
  assign ram_wdata = found_r ? (best_r - ROOM_W'(w_r)) : (cap_r - ROOM_W'(w_r));

  assign sts.too_heavy = (ROOM_W'(w_r) > cap_r);
  assign sts.none_open = (open_bins_r == '0);
  assign sts.scan_last = (scan_idx_r == scan_end_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  // Control state: configuration, bin bookkeeping, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAPACITY_RST;
      mode_r      <= FIT_NEXT;
      open_bins_r <= '0;
      cur_bin_r   <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_CAPACITY) begin
          cap_r <= cfg_wdata;
        end else begin
          mode_r <= cfg_wdata[1:0];
        end
      end
      if (cmd.accept && in_data.start_req) begin
        open_bins_r <= '0;
        cur_bin_r   <= '0;
      end
      if (cmd.place && !found_r && !full) begin
        open_bins_r <= open_inc;
        cur_bin_r   <= new_bin;
      end
      cmp_v_r <= cmd.rd_issue;
      if (cmd.eval) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      w_r <= in_data.weight & WEIGHT_MASK;
    end
    if (cmd.eval) begin
      // Next fit looks at the last opened bin only
      if (mode_r == FIT_NEXT) begin
        scan_idx_r <= cur_bin_r;
        scan_end_r <= cur_bin_r;
      end else begin
        scan_idx_r <= '0;
        scan_end_r <= BIN_W'(open_bins_r - 1'b1);
      end
      if (sts.too_heavy) begin
        res_r <= '{bin_index: '0, status: ST_TOO_HEAVY,
                   bins_used: OUT_CNT_W'(open_bins_r)};
      end
    end
    if (cmd.rd_issue) begin
      scan_idx_r <= BIN_W'(scan_idx_r + 1'b1);
      cmp_idx_r  <= scan_idx_r;
    end
    if (take) begin
      pick_r <= cmp_idx_r;
      best_r <= rd_room;
    end
    if (cmd.place) begin
      if (found_r) begin
        res_r <= '{bin_index: OUT_IDX_W'(pick_r), status: ST_PLACED,
                   bins_used: OUT_CNT_W'(open_bins_r)};
      end else if (full) begin
        res_r <= '{bin_index: '0, status: ST_NO_BINS,
                   bins_used: OUT_CNT_W'(open_bins_r)};
      end else begin
        res_r <= '{bin_index: OUT_IDX_W'(new_bin), status: ST_PLACED,
                   bins_used: OUT_CNT_W'(open_inc)};
      end
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
